[rtl/core/rcsp_pkg.sv]
package rcsp_pkg;

	// build-time limits and register reset values
	localparam int ArgsDefault = 64;
	localparam int BulkDefault = 1024 * 1024;
	localparam int LineMaxSpan = 20;
	localparam logic [6:0]  CfgArgsReset = 7'd64;
	localparam logic [20:0] CfgBulkReset = 21'h100000;

	// accumulator saturates just above any limit a 21-bit register can hold
	localparam int AccW = 22;
	localparam logic [AccW-1:0] AccSat = 22'h200000;

	// stream characters
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;

	typedef enum logic [3:0] {
		PH_STAR,
		PH_COUNT,
		PH_COUNT_CR,
		PH_DOLLAR,
		PH_LEN,
		PH_LEN_CR,
		PH_PAYLOAD,
		PH_CR,
		PH_LF
	} phase_t;

	typedef enum logic [2:0] {
		KIND_FRAME,
		KIND_PAYLOAD,
		KIND_DONE,
		KIND_ERROR,
		KIND_IGNORED
	} kind_t;

	typedef struct packed {
		logic [AccW-1:0] accum;
		logic [4:0]      span;
		logic            sign;
		logic            digit;
		logic            neg;
	} line_t;

	typedef struct packed {
		logic  ok;
		line_t line;
	} line_step_t;

	typedef struct packed {
		phase_t      phase;
		line_t       line;
		logic [6:0]  args_rem;
		logic [5:0]  cur_arg;
		logic [6:0]  count;
		logic [20:0] pay_rem;
		logic [20:0] cur_len;
		logic [23:0] byte_cnt;
		logic        err;
	} parse_state_t;

	typedef struct packed {
		kind_t       kind;
		logic [5:0]  arg_index;
		logic [20:0] arg_length;
		logic [7:0]  payload_byte;
		logic        last;
		logic [6:0]  arg_count;
		logic [23:0] command_bytes;
	} result_t;

	function automatic parse_state_t state_idle();
		parse_state_t s;
		s = '0;
		s.phase = PH_STAR;
		return s;
	endfunction

	// one character of a count or length line
	function automatic line_step_t line_char(line_t ln, logic [7:0] c);
		line_step_t r;
		logic [AccW+3:0] prod;
		logic flags_clear;
		r = '0;
		r.line = ln;
		flags_clear = !ln.sign && !ln.digit && !ln.neg;
		prod = ({4'b0, ln.accum} << 3) + ({4'b0, ln.accum} << 1) + (AccW+4)'(c[3:0]);
		if (ln.span >= 5'(LineMaxSpan)) begin
			r.ok = 1'b0;
		end else begin
			r.line.span = ln.span + 5'd1;
			if (c inside {CH_SPACE, [CH_TAB:CH_CR]}) begin
				r.ok = flags_clear;
			end else if (c inside {CH_PLUS, CH_MINUS}) begin
				r.ok = flags_clear;
				r.line.sign = 1'b1;
				r.line.neg = (c == CH_MINUS);
			end else if (c inside {[CH_ZERO:CH_NINE]}) begin
				r.ok = 1'b1;
				r.line.digit = 1'b1;
				if (prod >= (AccW+4)'(AccSat)) begin
					r.line.accum = AccSat;
				end else begin
					r.line.accum = prod[AccW-1:0];
				end
			end else begin
				r.ok = 1'b0;
			end
		end
		return r;
	endfunction

	// finished line against a limit; minus zero passes
	function automatic logic line_value_ok(line_t ln, logic [20:0] limit);
		return ln.digit && !(ln.neg && ln.accum != '0) && (ln.accum <= {1'b0, limit});
	endfunction

endpackage

[rtl/core/rcsp_step.sv]
module rcsp_step (
	input  rcsp_pkg::parse_state_t st,
	input  logic [7:0]             data_byte,
	input  logic [6:0]             lim_args,
	input  logic [20:0]            lim_bulk,
	output rcsp_pkg::parse_state_t st_next,
	output rcsp_pkg::result_t      res
);
	import rcsp_pkg::*;

	line_step_t   lc_byte;
	line_step_t   lc_cr;
	line_step_t   lc_cr_byte;
	parse_state_t upd;
	logic         ok;
	logic         done;
	logic [20:0]  pay_dec;
	logic [6:0]   args_dec;

	// plain character, and a stray cr followed by this byte
	assign lc_byte    = line_char(st.line, data_byte);
	assign lc_cr      = line_char(st.line, CH_CR);
	assign lc_cr_byte = line_char(lc_cr.line, data_byte);

	assign pay_dec  = (st.pay_rem != '0) ? st.pay_rem - 21'd1 : '0;
	assign args_dec = (st.args_rem != '0) ? st.args_rem - 7'd1 : '0;

	always_comb begin
		upd = st;
		ok = 1'b1;
		done = 1'b0;
		res = '0;
		res.kind = KIND_FRAME;
		upd.byte_cnt = (st.byte_cnt != '1) ? st.byte_cnt + 24'd1 : st.byte_cnt;
		if (st.err) begin
			res.kind = KIND_IGNORED;
		end else begin
			case (st.phase)
				PH_STAR: begin
					ok = (data_byte == CH_STAR);
					if (ok) begin
						upd.phase = PH_COUNT;
						upd.line = '0;
					end
				end
				PH_DOLLAR: begin
					ok = (data_byte == CH_DOLLAR);
					if (ok) begin
						upd.phase = PH_LEN;
						upd.line = '0;
					end
				end
				PH_COUNT, PH_LEN: begin
					if (data_byte == CH_CR) begin
						upd.phase = (st.phase == PH_COUNT) ? PH_COUNT_CR : PH_LEN_CR;
					end else begin
						ok = lc_byte.ok;
						upd.line = lc_byte.line;
					end
				end
				PH_COUNT_CR, PH_LEN_CR: begin
					if (data_byte == CH_LF) begin
						if (st.phase == PH_COUNT_CR) begin
							ok = line_value_ok(st.line, {14'b0, lim_args});
							if (ok) begin
								upd.count = st.line.accum[6:0];
								upd.args_rem = st.line.accum[6:0];
								upd.cur_arg = '0;
								if (st.line.accum == '0) begin
									done = 1'b1;
								end else begin
									upd.phase = PH_DOLLAR;
								end
							end
						end else begin
							ok = line_value_ok(st.line, lim_bulk);
							if (ok) begin
								upd.cur_len = st.line.accum[20:0];
								upd.pay_rem = st.line.accum[20:0];
								upd.phase = (st.line.accum != '0) ? PH_PAYLOAD : PH_CR;
							end
						end
					end else begin
						// the earlier cr was a line character after all
						ok = lc_cr.ok;
						upd.line = lc_cr.line;
						if (lc_cr.ok && data_byte != CH_CR) begin
							ok = lc_cr_byte.ok;
							upd.line = lc_cr_byte.line;
							upd.phase = (st.phase == PH_COUNT_CR) ? PH_COUNT : PH_LEN;
						end
					end
				end
				PH_PAYLOAD: begin
					res.kind = KIND_PAYLOAD;
					res.payload_byte = data_byte;
					upd.pay_rem = pay_dec;
					if (pay_dec == '0) begin
						res.last = 1'b1;
						upd.phase = PH_CR;
					end
				end
				PH_CR: begin
					ok = (data_byte == CH_CR);
					if (ok) begin
						upd.phase = PH_LF;
					end
				end
				PH_LF: begin
					ok = (data_byte == CH_LF);
					if (ok) begin
						upd.args_rem = args_dec;
						if (args_dec == '0) begin
							done = 1'b1;
						end else begin
							upd.cur_arg = st.cur_arg + 6'd1;
							upd.phase = PH_DOLLAR;
						end
					end
				end
				default: begin
					ok = 1'b0;
				end
			endcase
			if (!ok) begin
				upd.err = 1'b1;
				res.kind = KIND_ERROR;
				res.payload_byte = '0;
				res.last = 1'b0;
			end else if (done) begin
				res.kind = KIND_DONE;
			end
		end
		res.arg_index = upd.cur_arg;
		res.arg_length = upd.cur_len;
		res.arg_count = upd.count;
		res.command_bytes = upd.byte_cnt;
	end

	// per-command state clears once the completing beat is reported
	assign st_next = done ? state_idle() : upd;

endmodule

[rtl/core/resp_command_stream_parser.sv]
// channel   dir  handshake          contents
// s_*       in   s_tvalid/s_tready  tdata[7:0] data_byte
// m_*       out  m_tvalid/m_tready  tdata arg_index..command_bytes, tuser kind, tlast last_of_arg
// apb       in   psel/penable       0x0 max_args, 0x4 bulk length cap, pready tied high
//
// one byte in per cycle unless m stalls, one result per byte; input stage, then result stage
// throughput one beat per cycle unless m stalls, set by the single parser state update per byte
// arst_n clears parser state and both stage valids, limits go to 64 and 1048576
// a stalled m side holds the result; the input stage keeps taking beats until both stages fill
module resp_command_stream_parser #(
	parameter int MAX_ARGS = rcsp_pkg::ArgsDefault,
	parameter int MAX_BULK = rcsp_pkg::BulkDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	// stream in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	// stream out
	output logic        m_tvalid,
	input  logic        m_tready,
	// [5:0] arg_index, [26:6] arg_length, [34:27] payload_byte,
	// [41:35] arg_count, [65:42] command_bytes, [71:66] zero
	output logic [71:0] m_tdata,
	output logic [2:0]  m_tuser,   // [2:0] kind
	output logic        m_tlast,   // last_of_arg
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import rcsp_pkg::*;

	localparam logic REG_MAX_ARGS = 1'b0;
	localparam logic REG_MAX_BULK = 1'b1;

	// config registers
	logic [6:0]  max_args_q;
	logic [20:0] bulk_cap_q;
	logic [6:0]  lim_args;
	logic [20:0] lim_bulk;
	logic        cfg_wr;

	// pipeline
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         valid_s2;
	result_t      res_s2;
	logic         adv_s2;
	logic         move_s1;

	parse_state_t state_q;
	parse_state_t state_next;
	result_t      res;

	// apb: write on the access phase, word-addressed
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_args_q <= CfgArgsReset;
			bulk_cap_q <= CfgBulkReset;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_MAX_ARGS: max_args_q <= pwdata[6:0];
				REG_MAX_BULK: bulk_cap_q <= pwdata[20:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_MAX_ARGS: prdata = {25'b0, max_args_q};
			REG_MAX_BULK: prdata = {11'b0, bulk_cap_q};
			default: prdata = '0;
		endcase
	end

	// limit in use is the smaller of the register and the build-time cap
	assign lim_args = (32'(max_args_q) > MAX_ARGS) ? 7'(MAX_ARGS) : max_args_q;
	assign lim_bulk = (32'(bulk_cap_q) > MAX_BULK) ? 21'(MAX_BULK) : bulk_cap_q;

	// flow: result stage frees when empty or taken, input stage moves into it
	assign adv_s2   = !valid_s2 || m_tready;
	assign move_s1  = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	// parser step for the byte leaving the input stage
	rcsp_step u_step (
		.st        (state_q),
		.data_byte (byte_s1),
		.lim_args  (lim_args),
		.lim_bulk  (lim_bulk),
		.st_next   (state_next),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= state_idle();
		end else if (move_s1) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'b0, res_s2.command_bytes, res_s2.arg_count, res_s2.payload_byte,
		res_s2.arg_length, res_s2.arg_index};
	assign m_tuser  = res_s2.kind;
	assign m_tlast  = res_s2.last;

endmodule

[tb/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import rcsp_pkg::*;

	// register map, one word per register
	localparam logic [2:0] ADDR_MAX_ARGS = 3'h0;
	localparam logic [2:0] ADDR_MAX_BULK = 3'h4;

	// whitespace codes the package leaves out
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;

	// accumulator and byte counter ceilings of the parser behavior
	localparam int unsigned ACC_CAP   = 32'h1FF_FFFF;
	localparam int unsigned BYTES_CAP = 32'hFF_FFFF;
	localparam int unsigned LINE_SPAN = 20;

	localparam int unsigned CYCLE_LIMIT = 400000;

	// the one sticky fault that ends each run
	typedef enum int {
		FAULT_NO_STAR,
		FAULT_NO_DOLLAR,
		FAULT_BAD_CHAR,
		FAULT_LONG_LINE,
		FAULT_COUNT_LIMIT,
		FAULT_HUGE_LENGTH,
		FAULT_NEGATIVE,
		FAULT_NO_CR,
		FAULT_NO_LF,
		FAULT_EMPTY_LINE,
		FAULT_SIGN_LATE,
		FAULT_SPACE_LATE,
		FAULT_STRAY_CR,
		FAULT_NONE_OPEN_BULK
	} fault_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;   // [7:0] data_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	// [5:0] arg_index, [26:6] arg_length, [34:27] payload_byte,
	// [41:35] arg_count, [65:42] command_bytes, [71:66] zero
	logic [71:0] m_tdata;
	logic [2:0]  m_tuser;   // [2:0] kind
	logic        m_tlast;   // last_of_arg
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	resp_command_stream_parser dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// parser state as the testbench sees it
	// ---------------------------------------------------------------
	phase_t      ph = PH_STAR;
	int unsigned acc = 0;
	int unsigned span = 0;
	bit          f_sign = 0, f_digit = 0, f_neg = 0;
	int unsigned args_rem = 0, cur_arg = 0, count_l = 0;
	int unsigned pay_rem = 0, cur_len = 0, nbytes = 0;
	bit          stuck = 0;
	logic [6:0]  cfg_args = CfgArgsReset;
	logic [20:0] cfg_bulk = CfgBulkReset;

	result_t     byte_verdicts[$];   // one expected classification per accepted beat
	bit          calm = 0;           // no idling on either side while set
	int unsigned bytes_sent = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;
	int unsigned done_seen = 0;
	int unsigned payload_seen = 0;
	fault_t      fault;

	// effective limits: register clamped by the build-time maximum
	function automatic int unsigned args_limit();
		return (cfg_args < ArgsDefault) ? cfg_args : ArgsDefault;
	endfunction

	function automatic int unsigned bulk_limit();
		return (cfg_bulk < BulkDefault) ? cfg_bulk : BulkDefault;
	endfunction

	function automatic void line_reset();
		acc = 0;
		span = 0;
		f_sign = 0;
		f_digit = 0;
		f_neg = 0;
	endfunction

	// one character of a count or length line, 0 on a fault
	function automatic bit line_take(logic [7:0] c);
		int unsigned d;
		if (span >= LINE_SPAN)
			return 0;
		span++;
		// whitespace only before any sign or digit
		if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
			return !(f_sign || f_digit || f_neg);
		if (c == CH_PLUS || c == CH_MINUS) begin
			if (f_sign || f_digit || f_neg)
				return 0;
			f_sign = 1;
			f_neg = (c == CH_MINUS);
			return 1;
		end
		if (c >= CH_ZERO && c <= CH_NINE) begin
			d = c - CH_ZERO;
			f_digit = 1;
			// saturate so an oversized value always fails the limit
			if (acc > (ACC_CAP - d) / 10)
				acc = ACC_CAP;
			else
				acc = acc * 10 + d;
			return 1;
		end
		return 0;
	endfunction

	// minus zero passes, any other negative fails
	function automatic bit line_fits(int unsigned limit);
		return f_digit && !(f_neg && acc != 0) && acc <= limit;
	endfunction

	// advances the parser state by one byte and returns its classification
	function automatic result_t classify_byte(logic [7:0] b);
		result_t    r;
		kind_t      k;
		bit         ok, done, last;
		logic [7:0] pay;
		k = KIND_FRAME;
		ok = 1;
		done = 0;
		last = 0;
		pay = 8'h00;
		if (nbytes < BYTES_CAP)
			nbytes++;
		if (stuck) begin
			k = KIND_IGNORED;
		end else begin
			case (ph)
			PH_STAR: begin
				ok = (b == CH_STAR);
				if (ok) begin
					ph = PH_COUNT;
					line_reset();
				end
			end
			PH_DOLLAR: begin
				ok = (b == CH_DOLLAR);
				if (ok) begin
					ph = PH_LEN;
					line_reset();
				end
			end
			PH_COUNT, PH_LEN: begin
				if (b == CH_CR)
					ph = (ph == PH_COUNT) ? PH_COUNT_CR : PH_LEN_CR;
				else
					ok = line_take(b);
			end
			PH_COUNT_CR, PH_LEN_CR: begin
				if (b == CH_LF) begin
					if (ph == PH_COUNT_CR) begin
						ok = line_fits(args_limit());
						if (ok) begin
							count_l = acc;
							args_rem = acc;
							cur_arg = 0;
							if (args_rem == 0)
								done = 1;
							else
								ph = PH_DOLLAR;
						end
					end else begin
						ok = line_fits(bulk_limit());
						if (ok) begin
							cur_len = acc;
							pay_rem = acc;
							ph = (pay_rem != 0) ? PH_PAYLOAD : PH_CR;
						end
					end
				end else begin
					// the held cr becomes a line character
					ok = line_take(CH_CR);
					if (ok && b != CH_CR) begin
						ok = line_take(b);
						ph = (ph == PH_COUNT_CR) ? PH_COUNT : PH_LEN;
					end
				end
			end
			PH_PAYLOAD: begin
				k = KIND_PAYLOAD;
				pay = b;
				if (pay_rem != 0)
					pay_rem--;
				if (pay_rem == 0) begin
					last = 1;
					ph = PH_CR;
				end
			end
			PH_CR: begin
				ok = (b == CH_CR);
				if (ok)
					ph = PH_LF;
			end
			PH_LF: begin
				ok = (b == CH_LF);
				if (ok) begin
					if (args_rem != 0)
						args_rem--;
					if (args_rem == 0) begin
						done = 1;
					end else begin
						cur_arg++;
						ph = PH_DOLLAR;
					end
				end
			end
			default: ok = 0;
			endcase
			if (!ok) begin
				stuck = 1;
				k = KIND_ERROR;
				pay = 8'h00;
				last = 0;
			end else if (done) begin
				k = KIND_DONE;
			end
		end
		r.kind          = k;
		r.arg_index     = cur_arg[5:0];
		r.arg_length    = cur_len[20:0];
		r.payload_byte  = pay;
		r.last          = last;
		r.arg_count     = count_l[6:0];
		r.command_bytes = nbytes[23:0];
		// the completing beat reports final values, then the command state clears
		if (done) begin
			line_reset();
			args_rem = 0;
			cur_arg = 0;
			count_l = 0;
			pay_rem = 0;
			cur_len = 0;
			nbytes = 0;
			ph = PH_STAR;
		end
		return r;
	endfunction

	// ---------------------------------------------------------------
	// sender: one stream byte per call, valid held across back-to-back beats
	// ---------------------------------------------------------------
	task automatic push_byte(logic [7:0] b);
		if (!calm && $urandom_range(99) < 15) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		// every beat gives one result, so the prediction can go in now
		byte_verdicts.push_back(classify_byte(b));
		bytes_sent++;
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	// count or length line with random but legal shape, closed by cr lf
	task automatic send_number(int unsigned value);
		string       digits;
		logic [7:0]  chars[$];
		logic [7:0]  c, prev;
		int unsigned n_ws, n_zero, room;
		digits = $sformatf("%0d", value);
		n_ws = ($urandom_range(7) == 0) ? $urandom_range(1, 4) : 0;
		prev = 8'h00;
		repeat (n_ws) begin
			case ($urandom_range(5))
			0: c = CH_SPACE;
			1: c = CH_TAB;
			2: c = CH_LF;
			3: c = CH_VT;
			4: c = CH_FF;
			default: c = CH_CR;
			endcase
			// cr lf would end the line early
			if (prev == CH_CR && c == CH_LF)
				c = CH_SPACE;
			chars.push_back(c);
			prev = c;
		end
		case ($urandom_range(5))
		0: chars.push_back(CH_PLUS);
		1: if (value == 0) chars.push_back(CH_MINUS);
		default: ;
		endcase
		room = LINE_SPAN - chars.size() - digits.len();
		n_zero = ($urandom_range(7) == 0) ? $urandom_range(1, 5) : 0;
		// now and then a line of exactly the longest legal span
		if ($urandom_range(15) == 0 || n_zero > room)
			n_zero = room;
		repeat (n_zero)
			chars.push_back(CH_ZERO);
		for (int i = 0; i < digits.len(); i++)
			chars.push_back(digits[i]);
		foreach (chars[i])
			push_byte(chars[i]);
		push_byte(CH_CR);
		push_byte(CH_LF);
	endtask

	// one well-formed command with random payload
	task automatic send_command(int unsigned argc);
		int unsigned len, cap;
		cap = bulk_limit();
		push_byte(CH_STAR);
		send_number(argc);
		for (int unsigned i = 0; i < argc; i++) begin
			push_byte(CH_DOLLAR);
			if (argc > 8)
				len = $urandom_range(0, (cap < 3) ? cap : 3);
			else if ($urandom_range(19) == 0 && cap <= 600)
				len = cap;
			else if ($urandom_range(9) == 0)
				len = $urandom_range(0, (cap < 200) ? cap : 200);
			else
				len = $urandom_range(0, (cap < 12) ? cap : 12);
			send_number(len);
			repeat (len)
				push_byte($urandom_range(255));
			push_byte(CH_CR);
			push_byte(CH_LF);
		end
	endtask

	// drain: valid low, every expected beat back, then the pipeline latency
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (byte_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// ---------------------------------------------------------------
	// configuration port
	// ---------------------------------------------------------------
	task automatic reg_write(logic [2:0] addr, logic [31:0] wdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (addr == ADDR_MAX_ARGS)
			cfg_args = wdata[6:0];
		else
			cfg_bulk = wdata[20:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic reg_read_check(logic [2:0] addr, logic [31:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== want) begin
			mismatches++;
			$display("%0t prdata @%0h mismatch expected %0h actual %0h",
				$time, addr, want, prdata);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// both limits, with junk above the field width, then read back
	task automatic set_limits(logic [6:0] args_val, logic [20:0] bulk_val);
		logic [31:0] w;
		wait_idle();
		w = $urandom;
		w[6:0] = args_val;
		reg_write(ADDR_MAX_ARGS, w);
		w = $urandom;
		w[20:0] = bulk_val;
		reg_write(ADDR_MAX_BULK, w);
		reg_read_check(ADDR_MAX_ARGS, {25'd0, cfg_args});
		reg_read_check(ADDR_MAX_BULK, {11'd0, cfg_bulk});
	endtask

	// ---------------------------------------------------------------
	// result checker and receiver stalls
	// ---------------------------------------------------------------
	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			mismatches++;
			$display("%0t %s mismatch expected %0h actual %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (byte_verdicts.size() == 0) begin
				mismatches++;
				$display("%0t unexpected result beat expected none actual %0h/%0h",
					$time, m_tuser, m_tdata);
			end else begin
				want = byte_verdicts.pop_front();
				check_field("kind", want.kind, m_tuser);
				check_field("arg_index", want.arg_index, m_tdata[5:0]);
				check_field("arg_length", want.arg_length, m_tdata[26:6]);
				check_field("payload_byte", want.payload_byte, m_tdata[34:27]);
				check_field("last_of_arg", want.last, m_tlast);
				check_field("arg_count", want.arg_count, m_tdata[41:35]);
				check_field("command_bytes", want.command_bytes, m_tdata[65:42]);
				if (want.kind == KIND_DONE)
					done_seen++;
				if (want.kind == KIND_PAYLOAD)
					payload_seen++;
			end
		end
		// receiver stalls about 15 percent of the time, never while calm
		m_tready <= (calm || $urandom_range(99) >= 15);
	end

	// hang guard
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding",
				cycles, byte_verdicts.size());
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------

	// short commands right after reset, register reset values in force
	task automatic test_directed_shapes();
		// zero count completes on the lf of its count line
		send_text("*0\r\n");
		// cr as leading whitespace, minus zero as an empty bulk string
		send_text("*\r 1\r\n$-0\r\n\r\n");
		// payload byte extremes, last mark on the second
		send_text("*1\r\n$2\r\n");
		push_byte(8'h00);
		push_byte(8'hFF);
		send_text("\r\n");
	endtask

	// reset values, field masking and the top of each field
	task automatic test_register_access();
		wait_idle();
		reg_read_check(ADDR_MAX_ARGS, {25'd0, CfgArgsReset});
		reg_read_check(ADDR_MAX_BULK, {11'd0, CfgBulkReset});
		set_limits(7'h7F, 21'h1F_FFFF);
		set_limits(CfgArgsReset, CfgBulkReset);
	endtask

	// well-formed commands under the current limits until the byte budget runs out
	task automatic test_random_commands(int unsigned budget, bit full_count_first);
		int unsigned stop_at, lim, argc;
		stop_at = bytes_sent + budget;
		if (full_count_first)
			send_command(args_limit());
		while (bytes_sent < stop_at) begin
			lim = args_limit();
			case ($urandom_range(23))
			0: argc = 0;
			1: argc = lim;
			default: argc = $urandom_range((lim < 1) ? 0 : 1, (lim < 4) ? lim : 4);
			endcase
			send_command(argc);
		end
	endtask

	// a long stretch with valid and ready held high
	task automatic test_back_to_back(int unsigned budget);
		wait_idle();
		calm = 1;
		test_random_commands(budget, 0);
		wait_idle();
		calm = 0;
	endtask

	// one fault sticks until reset, so it closes the run; noise after it is ignored
	task automatic test_sticky_fault();
		set_limits(CfgArgsReset, 21'h1F_FFFF);
		fault = fault_t'($urandom_range(FAULT_NONE_OPEN_BULK));
		case (fault)
		FAULT_NO_STAR:     push_byte("G");
		FAULT_NO_DOLLAR:   send_text("*1\r\nx");
		FAULT_BAD_CHAR:    send_text("*1a");
		FAULT_LONG_LINE: begin
			push_byte(CH_STAR);
			repeat (LINE_SPAN + 1) push_byte(CH_ZERO);
		end
		FAULT_COUNT_LIMIT: send_text("*65\r\n");
		FAULT_HUGE_LENGTH: send_text("*1\r\n$99999999999999\r\n");
		FAULT_NEGATIVE:    send_text("*-3\r\n");
		FAULT_NO_CR:       send_text("*1\r\n$1\r\nab");
		FAULT_NO_LF:       send_text("*1\r\n$1\r\na\rx");
		FAULT_EMPTY_LINE:  send_text("*\r\n");
		FAULT_SIGN_LATE:   send_text("*1-");
		FAULT_SPACE_LATE:  send_text("*+ 1");
		FAULT_STRAY_CR:    send_text("*1\rx");
		default: begin
			// largest declared length, left open at the end of the run
			send_text("*1\r\n$1048576\r\n");
			repeat (40) push_byte($urandom_range(255));
		end
		endcase
		if (fault != FAULT_NONE_OPEN_BULK)
			repeat (40) push_byte($urandom_range(255));
	endtask

	initial begin
		arst_n  <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= 3'h0;
		pwdata  <= 32'h0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_shapes();
		test_register_access();
		// full argument count at the build maximum
		test_random_commands(300, 1);
		// registers above the build maximum clamp to it
		set_limits(7'h7F, 21'h1F_FFFF);
		test_random_commands(200, 0);
		// no arguments allowed: only empty commands
		set_limits(7'd0, 21'($urandom_range(0, 5000)));
		test_random_commands(80, 0);
		// one argument, empty strings only
		set_limits(7'd1, 21'd0);
		test_random_commands(100, 0);
		// small limits, hit exactly now and then
		set_limits(7'($urandom_range(1, 8)), 21'($urandom_range(1, 24)));
		test_random_commands(250, 0);
		set_limits(CfgArgsReset, 21'd40);
		test_back_to_back(250);
		set_limits(7'($urandom_range(2, 64)), 21'($urandom_range(0, 1048576)));
		test_random_commands(150, 0);
		test_sticky_fault();

		wait_idle();
		repeat (8) @(posedge clk);
		$display("sent %0d stream beats: %0d commands completed, %0d payload beats",
			bytes_sent, done_seen, payload_seen);
		$display("limits swept from zero to field maximum, closing case %s", fault.name());
		if (mismatches == 0 && byte_verdicts.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
